[src/adbi_pkg.sv]
package adbi_pkg;

    localparam int BLOCK_INPUTS_DEF = 64;
    localparam int DECIM_TAPS  = 31;
    localparam int INTERP_TAPS = 32;
    localparam int INTERP_PHASE = INTERP_TAPS / 2;
    localparam int CLIP_LIMIT  = 32112;
    localparam int CLIP_RUN_MIN = 7;

    // configuration register indexes
    localparam logic [2:0] REG_B0 = 3'd0;
    localparam logic [2:0] REG_B1 = 3'd1;
    localparam logic [2:0] REG_B2 = 3'd2;
    localparam logic [2:0] REG_A1 = 3'd3;
    localparam logic [2:0] REG_A2 = 3'd4;

    // half-band decimator taps
    function automatic logic signed [15:0] decim_coef(input logic [4:0] idx);
        logic signed [15:0] c;
        case (idx)
            5'd0, 5'd30: c = -16'sd56;
            5'd2, 5'd28: c = 16'sd96;
            5'd4, 5'd26: c = -16'sd221;
            5'd6, 5'd24: c = 16'sd462;
            5'd8, 5'd22: c = -16'sd878;
            5'd10, 5'd20: c = 16'sd1609;
            5'd12, 5'd18: c = -16'sd3176;
            5'd14, 5'd16: c = 16'sd10342;
            5'd15: c = 16'sd16410;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

    // interpolator taps
    function automatic logic signed [15:0] interp_coef(input logic [4:0] idx);
        logic signed [15:0] c;
        case (idx)
            5'd0, 5'd31: c = -16'sd76;
            5'd1, 5'd30: c = -16'sd91;
            5'd2, 5'd29: c = 16'sd128;
            5'd3, 5'd28: c = 16'sd192;
            5'd4, 5'd27: c = -16'sd287;
            5'd5, 5'd26: c = -16'sd418;
            5'd6, 5'd25: c = 16'sd592;
            5'd7, 5'd24: c = 16'sd818;
            5'd8, 5'd23: c = -16'sd1110;
            5'd9, 5'd22: c = -16'sd1490;
            5'd10, 5'd21: c = 16'sd1996;
            5'd11, 5'd20: c = 16'sd2699;
            5'd12, 5'd19: c = -16'sd3755;
            5'd13, 5'd18: c = -16'sd5571;
            5'd14, 5'd17: c = 16'sd9647;
            default: c = 16'sd29495;
        endcase
        return c;
    endfunction

    // saturate a 48-bit value (an accumulator already shifted right) to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767)
            r = 16'sh7fff;
        else if (v < -48'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

[src/adbi_mac.sv]
module adbi_mac
    import adbi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clr,
    input  logic               en,
    input  logic signed [15:0] op_a,
    input  logic signed [15:0] op_b,
    output logic signed [47:0] acc
);

    logic signed [31:0] prod_reg;
    logic               pv_reg;
    logic signed [47:0] acc_reg;

    // registered product then accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg <= en;
            if (clr)
                acc_reg <= '0;
            else if (pv_reg)
                acc_reg <= acc_reg + 48'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign acc = acc_reg;

endmodule

[src/audio_decimate_biquad_interpolate.sv]
// an odd-phase request gives its first result after the decimator, biquad and interpolator passes,
// and the second after the first is taken; an even-phase request gives none
// one request at a time runs on one shared multiply-accumulate; a waiting result holds the input
// until the output register empties
// reset: asynchronous active low; clears control, history memories are swept to zero
// in a sweep after reset, during which no request is accepted
module audio_decimate_biquad_interpolate
    import adbi_pkg::*;
#(
    parameter int BLOCK_INPUTS = BLOCK_INPUTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] adc_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] dac_sample,
    output logic        pair_last,
    output logic        clip_led,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int BPW = $clog2(BLOCK_INPUTS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_DDRAIN, S_BQ, S_BDRAIN, S_INT, S_IDRAIN, S_OUT
    } state_t;

    state_t state_reg;

    // memories: decimator line (circular) and interpolator line (circular)
    logic signed [15:0] dmem [DECIM_TAPS];
    logic signed [15:0] imem [INTERP_PHASE];
    logic signed [15:0] drd_reg, ird_reg;

    logic [4:0] dhead_reg;          // index of next write (oldest entry)
    logic [3:0] ihead_reg;
    logic [4:0] cnt_reg;
    logic       phase_reg;
    logic       j_reg;
    logic [BPW-1:0] bpos_reg;
    logic [2:0] run_reg;
    logic       seen_reg, led_reg;
    logic signed [15:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [15:0] x1_reg, x2_reg, y1_reg, y2_reg, d_reg;
    logic       blkend_reg;

    // mac control
    logic               mclr, men;
    logic signed [15:0] ma, mb;
    logic signed [47:0] macc;
    logic [2:0]         mdly_reg;

    adbi_mac u_mac (
        .clk(clk), .rst_n(rst_n), .clr(mclr), .en(men),
        .op_a(ma), .op_b(mb), .acc(macc)
    );

    assign in_ready  = (state_reg == S_IDLE) && !out_valid;
    assign cfg_ready = 1'b1;

    // read addresses
    logic [5:0] dsum;
    logic [4:0] daddr;
    logic [3:0] iaddr;
    assign dsum  = 6'(dhead_reg) + 6'(cnt_reg);
    assign daddr = (dsum >= 6'(DECIM_TAPS)) ? 5'(dsum - 6'(DECIM_TAPS)) : dsum[4:0];
    assign iaddr = ihead_reg + cnt_reg[3:0];

    // memory reads, registered
    always_ff @(posedge clk)
    begin
        drd_reg <= dmem[daddr];
        ird_reg <= imem[iaddr];
    end

    // operand select, driven from registered copies of the count and state to line up with the reads
    logic [4:0] cnt_d_reg;
    logic       mact_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_d_reg <= '0;
            mact_reg  <= 1'b0;
        end
        else
        begin
            cnt_d_reg <= cnt_reg;
            mact_reg  <= (state_reg == S_DEC) || (state_reg == S_BQ) || (state_reg == S_INT);
        end
    end

    logic [2:0] sd_reg;
    always_ff @(posedge clk)
    begin
        sd_reg <= 3'(state_reg == S_DEC) | (3'(state_reg == S_BQ) << 1)
                  | (3'(state_reg == S_INT) << 2);
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        if (sd_reg[0])
        begin
            ma = decim_coef(cnt_d_reg);
            mb = drd_reg;
        end
        else if (sd_reg[1])
        begin
            case (cnt_d_reg[2:0])
                3'd0: begin ma = b0_reg; mb = d_reg; end
                3'd1: begin ma = b1_reg; mb = x1_reg; end
                3'd2: begin ma = b2_reg; mb = x2_reg; end
                3'd3: begin ma = a1_reg; mb = y1_reg; end
                default: begin ma = a2_reg; mb = y2_reg; end
            endcase
        end
        else if (sd_reg[2])
        begin
            ma = interp_coef(5'({cnt_d_reg[3:0], 1'b0}) + 5'(!j_reg));
            mb = ird_reg;
        end
    end
    assign men  = mact_reg;
    assign mclr = (state_reg == S_IDLE) || (mdly_reg == 3'd1);

    // shifted and saturated accumulator results
    logic signed [15:0] dec_val, bq_val, int_val;
    logic signed [47:0] s15, s14;
    assign s15 = macc >>> 15;
    assign s14 = macc >>> 14;
    assign dec_val = sat16(s15);
    assign bq_val  = sat16(s14);
    assign int_val = sat16(s15);

    logic clipped;
    assign clipped = (dec_val > 16'sd32112) || (dec_val < -16'sd32112);

    logic [15:0] xin;
    assign xin = {adc_sample - 12'd2048, 4'b0};

    logic [2:0] run_next;
    assign run_next = clipped ? ((run_reg < 3'(CLIP_RUN_MIN)) ? run_reg + 3'd1 : run_reg)
                              : 3'd0;

    // memory write ports: sweep after reset, new sample, new biquad output
    logic               dwe, iwe;
    logic [4:0]         dwaddr;
    logic [3:0]         iwaddr;
    logic signed [15:0] dwdata, iwdata;
    assign dwe    = (state_reg == S_CLEAR)
                    || ((state_reg == S_IDLE) && in_valid && in_ready);
    assign dwaddr = (state_reg == S_CLEAR) ? cnt_reg : dhead_reg;
    assign dwdata = (state_reg == S_CLEAR) ? 16'sd0 : xin;
    assign iwe    = (state_reg == S_CLEAR)
                    || ((state_reg == S_BDRAIN) && (mdly_reg == 3'd2));
    assign iwaddr = (state_reg == S_CLEAR) ? cnt_reg[3:0] : ihead_reg;
    assign iwdata = (state_reg == S_CLEAR) ? 16'sd0 : bq_val;

    always_ff @(posedge clk)
    begin
        if (dwe)
            dmem[dwaddr] <= dwdata;
        if (iwe)
            imem[iwaddr] <= iwdata;
    end

    // control and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            dhead_reg  <= '0;
            ihead_reg  <= '0;
            cnt_reg    <= '0;
            phase_reg  <= 1'b0;
            j_reg      <= 1'b0;
            bpos_reg   <= '0;
            run_reg    <= '0;
            seen_reg   <= 1'b0;
            led_reg    <= 1'b0;
            blkend_reg <= 1'b0;
            out_valid  <= 1'b0;
            mdly_reg   <= '0;
            b0_reg <= 16'sd16384;
            b1_reg <= '0; b2_reg <= '0; a1_reg <= '0; a2_reg <= '0;
            x1_reg <= '0; x2_reg <= '0; y1_reg <= '0; y2_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_B0: b0_reg <= cfg_data;
                    REG_B1: b1_reg <= cfg_data;
                    REG_B2: b2_reg <= cfg_data;
                    REG_A1: a1_reg <= cfg_data;
                    REG_A2: a2_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (mdly_reg != 3'd0)
                mdly_reg <= mdly_reg - 3'd1;

            unique case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DECIM_TAPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        dhead_reg <= (dhead_reg == 5'(DECIM_TAPS - 1)) ? 5'd0
                                     : dhead_reg + 5'd1;
                        phase_reg <= !phase_reg;
                        blkend_reg <= (32'(bpos_reg) >= BLOCK_INPUTS - 1);
                        bpos_reg <= (32'(bpos_reg) >= BLOCK_INPUTS - 1) ? '0
                                    : bpos_reg + BPW'(1);
                        cnt_reg <= '0;
                        if (phase_reg)
                            state_reg <= S_DEC;
                        else if (32'(bpos_reg) >= BLOCK_INPUTS - 1)
                        begin
                            led_reg  <= seen_reg;
                            seen_reg <= 1'b0;
                            run_reg  <= '0;
                        end
                    end
                end
                S_DEC:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DECIM_TAPS - 1))
                    begin
                        state_reg <= S_DDRAIN;
                        mdly_reg  <= 3'd4;
                    end
                end
                S_DDRAIN:
                begin
                    if (mdly_reg == 3'd2)
                    begin
                        d_reg   <= dec_val;
                        run_reg <= run_next;
                        if (blkend_reg)
                        begin
                            led_reg  <= seen_reg || (run_next >= 3'(CLIP_RUN_MIN));
                            seen_reg <= 1'b0;
                            run_reg  <= '0;
                        end
                        else if (run_next >= 3'(CLIP_RUN_MIN))
                            seen_reg <= 1'b1;
                    end
                    if (mdly_reg == 3'd1)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_BQ;
                    end
                end
                S_BQ:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd4)
                    begin
                        state_reg <= S_BDRAIN;
                        mdly_reg  <= 3'd4;
                    end
                end
                S_BDRAIN:
                begin
                    if (mdly_reg == 3'd2)
                    begin
                        x2_reg <= x1_reg;
                        x1_reg <= d_reg;
                        y2_reg <= y1_reg;
                        y1_reg <= bq_val;
                        ihead_reg <= ihead_reg + 4'd1;
                    end
                    if (mdly_reg == 3'd1)
                    begin
                        cnt_reg   <= '0;
                        j_reg     <= 1'b0;
                        state_reg <= S_INT;
                    end
                end
                S_INT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(INTERP_PHASE - 1))
                    begin
                        state_reg <= S_IDRAIN;
                        mdly_reg  <= 3'd4;
                    end
                end
                S_IDRAIN:
                begin
                    if (mdly_reg == 3'd2 && !out_valid)
                    begin
                        dac_sample <= 12'(int_val >>> 4) + 12'd2048;
                        pair_last  <= j_reg;
                        clip_led   <= led_reg;
                        out_valid  <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                    else if (mdly_reg == 3'd2)
                        mdly_reg <= 3'd2;
                end
                S_OUT:
                begin
                    if (j_reg)
                        state_reg <= S_IDLE;
                    else if (!out_valid || out_ready)
                    begin
                        j_reg     <= 1'b1;
                        cnt_reg   <= '0;
                        mdly_reg  <= '0;
                        state_reg <= S_INT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result count never exceeds one held entry
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result lost");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && pair_last) |=> (state_reg == S_IDLE || !out_valid))
        else $error("pair order");

endmodule
